### hdl/dbto_pkg.sv
// ----------------------------------------------------------------------------
// dbto_pkg
// Shared types and constants of the depth buffer: operation codes, payload
// structs of both channels and the command word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package dbto_pkg;

    localparam int COORD_W    = 10;
    localparam int DEPTH_W    = 24;
    localparam int TILE_SHIFT = 3;                  // tiles are 8 x 8 pixels
    localparam int TILE_SIZE  = 1 << TILE_SHIFT;
    localparam int TILE_IW    = COORD_W - TILE_SHIFT;
    localparam int DIM_RESET  = 512;

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = {DEPTH_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_TEST  = 2'd1,
        OP_WRITE = 2'd2,
        OP_QUERY = 2'd3
    } op_e;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_last;
        logic [DEPTH_W-1:0] depth_a;
        logic [DEPTH_W-1:0] depth_b;
        logic [DEPTH_W-1:0] depth_c;
    } item_t;

    typedef struct packed {
        logic passed;
        logic not_occluded;
        logic is_query;
    } result_t;

    // classified command: depth is the clear/write/test value or the
    // largest vertex depth of a query
    typedef struct packed {
        op_e                op;
        logic               in_area;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TILE_IW-1:0] c0;
        logic [TILE_IW-1:0] c1;
        logic [TILE_IW-1:0] r0;
        logic [TILE_IW-1:0] r1;
        logic [DEPTH_W-1:0] depth;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/depth_buffer_test_and_occlusion.sv
// ----------------------------------------------------------------------------
// depth_buffer_test_and_occlusion
// Depth buffer with per-pixel depth, per-tile minimum depth and a triangle
// occlusion query, queue-style on both sides.
// ----------------------------------------------------------------------------
// Items enter through a two-word command queue and are executed one at a
// time by a sequencer that owns a single-port-per-side pixel memory and a
// tile memory. A write is done when it is popped; a depth test first does a
// registered pixel read and compares in the S_TEST state. A triangle query
// steps over the covered tiles in S_QUERY, one tile read a cycle, and pushes
// its result from S_DRAIN. A clear writes every pixel in turn in S_CLEAR;
// the tile minimums are written during the first TILE_DEPTH entries of the
// sweep. Both memories hold garbage until the first clear. Results wait in a
// two-word output queue, so the front keeps taking items while a result is
// not yet popped.
`default_nettype none

module depth_buffer_test_and_occlusion
    import dbto_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [COORD_W-1:0] cfg_data,
    input  wire logic               push,
    input  wire item_t              item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output result_t                 result
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    cmd_t    front_cmd, back_cmd;
    logic    cmd_empty, cmd_pop;
    logic    res_full, res_push;
    result_t back_res;

    dbto_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (front_cmd)
    );

    dbto_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    dbto_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    dbto_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

### hdl/dbto_fifo.sv
// ----------------------------------------------------------------------------
// dbto_fifo
// Small register queue with first-word fall-through, used between the front
// and back ends and for the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module dbto_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // advance pointers, wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### hdl/dbto_front.sv
// ----------------------------------------------------------------------------
// dbto_front
// Configuration registers and item classification: pixel bounds check,
// tile bounds of a query box and the largest vertex depth.
// ----------------------------------------------------------------------------
`default_nettype none

module dbto_front
    import dbto_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [COORD_W-1:0] cfg_data,
    input  wire item_t              item,
    output cmd_t                    cmd
);

    localparam int W_RESET = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
    localparam int H_RESET = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

    logic [COORD_W-1:0] width_reg, height_reg;
    logic [COORD_W:0]   tw_sum, th_sum;
    logic [TILE_IW:0]   tile_w, tile_h;
    logic [TILE_IW-1:0] c1_raw, r1_raw;
    logic [DEPTH_W-1:0] max_ab;

    function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v,
                                                     input int top);
        logic [COORD_W-1:0] r;
        if (v == '0)
        begin
            r = COORD_W'(1);
        end
        else if (32'(v) > top)
        begin
            r = COORD_W'(top);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // take configuration writes, saturated to the legal range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COORD_W'(W_RESET);
            height_reg <= COORD_W'(H_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= clamp_dim(cfg_data, MAX_WIDTH);
                REG_HEIGHT: height_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
                default:    ;
            endcase
        end
    end

    // tile counts of the area in use, rounded up
    assign tw_sum = {1'b0, width_reg} + (COORD_W + 1)'(TILE_SIZE - 1);
    assign th_sum = {1'b0, height_reg} + (COORD_W + 1)'(TILE_SIZE - 1);
    assign tile_w = tw_sum[COORD_W:TILE_SHIFT];
    assign tile_h = th_sum[COORD_W:TILE_SHIFT];
    assign c1_raw = item.x_last[COORD_W-1:TILE_SHIFT];
    assign r1_raw = item.y_last[COORD_W-1:TILE_SHIFT];

    assign max_ab = (item.depth_a > item.depth_b) ? item.depth_a : item.depth_b;

    // classify the item into a command word
    always_comb
    begin
        cmd.op      = op_e'(item.operation);
        cmd.in_area = (item.x_first < width_reg) && (item.y_first < height_reg);
        cmd.x       = item.x_first;
        cmd.y       = item.y_first;
        cmd.c0      = item.x_first[COORD_W-1:TILE_SHIFT];
        cmd.r0      = item.y_first[COORD_W-1:TILE_SHIFT];
        cmd.c1      = ({1'b0, c1_raw} > tile_w) ? tile_w[TILE_IW-1:0] : c1_raw;
        cmd.r1      = ({1'b0, r1_raw} > tile_h) ? tile_h[TILE_IW-1:0] : r1_raw;
        if (op_e'(item.operation) == OP_QUERY)
        begin
            cmd.depth = (max_ab > item.depth_c) ? max_ab : item.depth_c;
        end
        else
        begin
            cmd.depth = item.depth_a;
        end
    end

endmodule

`default_nettype wire

### hdl/dbto_back.sv
// ----------------------------------------------------------------------------
// dbto_back
// Execution sequencer: owns the pixel and tile memories, sweeps clears,
// runs depth tests and writes, and folds tile minimums for queries.
// ----------------------------------------------------------------------------
`default_nettype none

module dbto_back
    import dbto_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    input  wire logic res_full,
    output logic      res_push,
    output result_t   res
);

    localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_AW     = $clog2(PIX_DEPTH);
    localparam int TILE_COLS  = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TILE_ROWS  = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TILE_DEPTH = TILE_COLS * TILE_ROWS;
    localparam int TILE_AW    = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_TEST  = 5'b00100,
        S_QUERY = 5'b01000,
        S_DRAIN = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [PIX_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               inside_reg, inside_next;
    logic [TILE_IW-1:0] row_reg, row_next;
    logic [TILE_IW-1:0] col_reg, col_next;
    logic [TILE_IW-1:0] c0_reg, c0_next;
    logic [TILE_IW-1:0] c1_reg, c1_next;
    logic [TILE_IW-1:0] r1_reg, r1_next;
    logic [DEPTH_W-1:0] min_reg, min_next;
    logic               rd_valid_reg;

    // pixel memory ports
    logic               pix_we, pix_re;
    logic [PIX_AW-1:0]  pix_waddr, pix_raddr, cmd_addr;
    logic [DEPTH_W-1:0] pix_wdata, pix_rdata;
    logic [DEPTH_W-1:0] pix_mem [PIX_DEPTH];

    // tile memory ports: only the range minimum is ever read, so the
    // maximum half is not kept
    logic               tile_we, tile_re;
    logic [TILE_AW-1:0] tile_waddr, tile_raddr;
    logic [DEPTH_W-1:0] tile_rdata;
    logic [DEPTH_W-1:0] tile_mem [TILE_DEPTH];

    logic               clear_last, col_last, row_last, needs_room;
    logic [DEPTH_W-1:0] min_fold;

    assign cmd_addr   = PIX_AW'(32'(cmd.y) * MAX_WIDTH + 32'(cmd.x));
    assign clear_last = (clr_cnt_reg == PIX_AW'(PIX_DEPTH - 1));
    assign col_last   = ({1'b0, col_reg} + 1'b1) == {1'b0, c1_reg};
    assign row_last   = ({1'b0, row_reg} + 1'b1) == {1'b0, r1_reg};
    assign min_fold   = (rd_valid_reg && tile_rdata < min_reg) ? tile_rdata : min_reg;
    assign needs_room = (cmd.op == OP_TEST) || (cmd.op == OP_QUERY);

    // take a command only when its result has a slot waiting
    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty && !(needs_room && res_full);

    // sequence the operations
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        depth_next   = depth_reg;
        inside_next  = inside_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        c0_next      = c0_reg;
        c1_next      = c1_reg;
        r1_next      = r1_reg;
        min_next     = min_reg;
        pix_we       = 1'b0;
        pix_re       = 1'b0;
        pix_waddr    = cmd_addr;
        pix_raddr    = cmd_addr;
        pix_wdata    = cmd.depth;
        tile_we      = 1'b0;
        tile_re      = 1'b0;
        tile_waddr   = clr_cnt_reg[TILE_AW-1:0];
        tile_raddr   = TILE_AW'(32'(row_reg) * TILE_COLS + 32'(col_reg));
        res_push     = 1'b0;
        res          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    depth_next  = cmd.depth;
                    inside_next = cmd.in_area;
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        OP_WRITE:
                        begin
                            pix_we = cmd.in_area;
                        end
                        OP_TEST:
                        begin
                            pix_re     = 1'b1;
                            state_next = S_TEST;
                        end
                        default:
                        begin
                            row_next = cmd.r0;
                            col_next = cmd.c0;
                            c0_next  = cmd.c0;
                            c1_next  = cmd.c1;
                            r1_next  = cmd.r1;
                            min_next = DEPTH_FULL;
                            if (cmd.c0 < cmd.c1 && cmd.r0 < cmd.r1)
                            begin
                                state_next = S_QUERY;
                            end
                            else
                            begin
                                state_next = S_DRAIN;
                            end
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                // sweep both memories, one entry a cycle
                pix_we       = 1'b1;
                pix_waddr    = clr_cnt_reg;
                pix_wdata    = depth_reg;
                tile_we      = (32'(clr_cnt_reg) < TILE_DEPTH);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_TEST:
            begin
                res_push   = 1'b1;
                res.passed = inside_reg && (depth_reg <= pix_rdata);
                state_next = S_IDLE;
            end

            S_QUERY:
            begin
                // issue one tile read a cycle, fold the previous one
                tile_re  = 1'b1;
                min_next = min_fold;
                if (col_last)
                begin
                    col_next = c0_reg;
                    row_next = row_reg + 1'b1;
                    if (row_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                res_push         = 1'b1;
                res.is_query     = 1'b1;
                res.not_occluded = (depth_reg < min_fold);
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= tile_re;
        end
    end

    // hold operands
    always_ff @(posedge clk)
    begin
        clr_cnt_reg <= clr_cnt_next;
        depth_reg   <= depth_next;
        inside_reg  <= inside_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        r1_reg      <= r1_next;
        min_reg     <= min_next;
    end

    // pixel memory, registered read
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (pix_re)
        begin
            pix_rdata <= pix_mem[pix_raddr];
        end
    end

    // tile minimum memory, registered read
    always_ff @(posedge clk)
    begin
        if (tile_we)
        begin
            tile_mem[tile_waddr] <= depth_reg;
        end
        if (tile_re)
        begin
            tile_rdata <= tile_mem[tile_raddr];
        end
    end

    // a result is only pushed when the queue has room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // a popped test moves to its compare state in the next cycle
    a_test_next: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.op == OP_TEST) |=> (state_reg == S_TEST))
        else $error("test did not move to the compare cycle");

    // the clear sweep steps by one until its last entry
    a_clear_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !clear_last) |=>
            (state_reg == S_CLEAR && clr_cnt_reg == $past(clr_cnt_reg) + 1'b1))
        else $error("clear sweep skipped or stopped early");

    // no command leaves the queue while a sequence is running
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> $past(state_reg) == S_IDLE && $onehot(state_reg))
        else $error("command popped outside idle");

endmodule

`default_nettype wire
